FILE: sv/rtdi_pkg.sv
`timescale 1ns / 1ps
// rtdi_pkg: field widths, types, mode and register codes for the RTD table interpolator.
// No dependencies; used by the channel interfaces and the top level.
package rtdi_pkg;

    localparam int MODE_W     = 2;
    localparam int ENTRY_W    = 11;
    localparam int RES_W      = 20;
    localparam int TEMP_W     = 21;
    localparam int STEP_W     = 17;
    localparam int LAST_W     = 11;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef logic [MODE_W-1:0]         mode_t;
    typedef logic [ENTRY_W-1:0]        entry_t;
    typedef logic [RES_W-1:0]          resistance_t;
    typedef logic signed [TEMP_W-1:0]  temperature_t;
    typedef logic [STEP_W-1:0]         step_t;
    typedef logic [LAST_W-1:0]         last_t;
    typedef logic [1:0]                reg_idx_t;

    localparam mode_t MODE_LOAD = 2'd0;
    localparam mode_t MODE_R2T  = 2'd1;
    localparam mode_t MODE_T2R  = 2'd2;

    localparam reg_idx_t REG_START = 2'd0;
    localparam reg_idx_t REG_STEP  = 2'd1;
    localparam reg_idx_t REG_LAST  = 2'd2;

    localparam temperature_t START_RST = -21'sd200000;
    localparam step_t        STEP_RST  = 17'd1000;
    localparam last_t        LAST_RST  = 11'd1050;

    localparam int T_OUT_MIN = -1048576;
    localparam int T_OUT_MAX = 1048575;
    localparam int R_OUT_MAX = 1048575;

endpackage

FILE: sv/rtdi_if.sv
`timescale 1ns / 1ps
// rtdi_in_if / rtdi_out_if: valid/ready item channels of the RTD table interpolator.
// Depends on rtdi_pkg for payload types.
interface rtdi_in_if;
    import rtdi_pkg::*;

    logic         valid;
    logic         ready;
    mode_t        mode;
    entry_t       entry_index;
    resistance_t  resistance;
    temperature_t temperature;

    modport source (output valid, output mode, output entry_index, output resistance,
                    output temperature, input ready);
    modport sink   (input valid, input mode, input entry_index, input resistance,
                    input temperature, output ready);
endinterface

interface rtdi_out_if;
    import rtdi_pkg::*;

    logic         valid;
    logic         ready;
    temperature_t temperature_out;
    resistance_t  resistance_out;

    modport source (output valid, output temperature_out, output resistance_out, input ready);
    modport sink   (input valid, input temperature_out, input resistance_out, output ready);
endinterface

FILE: sv/rtdi_divider.sv
`timescale 1ns / 1ps
// rtdi_divider: shared restoring divider, one quotient bit per cycle.
// Standalone; instantiated by rtd_table_interpolator_core.
module rtdi_divider #(
    parameter int DIV_W = 37,
    parameter int DV_W  = 20,
    parameter int QW    = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [$clog2(QW+1)-1:0]      qbits,
    input  logic [DIV_W-1:0]             dividend,
    input  logic [DV_W-1:0]              divisor,
    output logic                         done,
    output logic [QW-1:0]                quotient,
    output logic [DIV_W-1:0]             remainder
);

    localparam int CNT_W = $clog2(QW+1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsh_reg, dsh_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic             ge;

    assign ge = rem_reg >= dsh_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = qbits;
            rem_next  = dividend;
            dsh_next  = DIV_W'(divisor) << (qbits - 1'b1);
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[QW-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: sv/rtd_table_interpolator_core.sv
`timescale 1ns / 1ps
// rtd_table_interpolator_core: PT100 resistance <-> temperature by table interpolation.
// Load item: passes through ST_EMIT to the output register.
// Resistance to temperature: binary search over the table memory port, then a 17-bit divide.
// Temperature to resistance: two serial divides.
// One item at a time. Reset restores the configuration; table contents stay undefined until loaded.
module rtd_table_interpolator_core #(
    parameter int TABLE_DEPTH     = 2048,
    parameter int RESISTANCE_BITS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtdi_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rtdi_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rtdi_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    rtdi_in_if.sink                           in_item,
    rtdi_out_if.source                        out_item
);

    import rtdi_pkg::*;

    localparam int RB     = RESISTANCE_BITS;
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int MB     = (RB > IDX_W) ? RB : IDX_W;
    localparam int PROD_W = STEP_W + MB;
    localparam int QW     = (MB > STEP_W) ? MB : STEP_W;
    localparam int DV_W   = (RB > STEP_W) ? RB : STEP_W;
    localparam int CNT_W  = $clog2(QW+1);
    localparam int TSUM_W = PROD_W + 2;
    localparam int RS_W   = ((RB + 3) > 22) ? (RB + 3) : 22;
    localparam int CW     = (RB > RES_W) ? RB : RES_W;
    localparam int LW     = (IDX_W > LAST_W) ? IDX_W : LAST_W;
    localparam int EW     = ((IDX_W > ENTRY_W) ? IDX_W : ENTRY_W) + 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_EMIT,
        M1_A, M1_B, M1_C, M1_SW, M1_SC, M1_FOUND, M1_R1W, M1_R1, M1_R2,
        M1_DIV, M1_DIVW, M1_FIN,
        M2_SPAN, M2_CLAMP, M2_IDXW, M2_IDX, M2_R1W, M2_R1, M2_R2,
        M2_DIV, M2_DIVW, M2_FIN
    } state_t;

    // configuration
    temperature_t start_temp_reg, start_temp_next;
    step_t        step_reg, step_next;
    last_t        last_reg, last_next;
    logic         cfg_we;
    step_t        step_eff;
    logic [LW-1:0]    last_wide;
    logic [IDX_W-1:0] last_eff;
    logic [IDX_W-1:0] last_m1;

    // control
    state_t       state_reg, state_next;
    logic         out_valid_reg, out_valid_next;
    temperature_t t_out_reg, t_out_next;
    resistance_t  r_out_reg, r_out_next;
    logic         accept;

    // datapath
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [RB-1:0]     rd_data_reg;
    resistance_t       r_in_reg, r_in_next;
    temperature_t      t_in_reg, t_in_next;
    logic [RB-1:0]     rmin_reg, rmin_next;
    logic [RB-1:0]     r_reg, r_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [RB-1:0]     r1_reg, r1_next;
    logic [RB-1:0]     den_reg, den_next;
    logic              frac_en_reg, frac_en_next;
    step_t             rem_reg, rem_next;
    logic              neg_reg, neg_next;
    temperature_t      res_t_reg, res_t_next;
    resistance_t       res_r_reg, res_r_next;
    logic [PROD_W-1:0] mul_reg, mul_next;

    // table memory
    logic [RB-1:0]     table_mem [TABLE_DEPTH];
    logic [EW-1:0]     ent_wide;
    logic              mem_we;

    // shared multiplier operands
    step_t             mul_a;
    logic [MB-1:0]     mul_b;

    // shared divider
    logic              div_start;
    logic [CNT_W-1:0]  div_qbits;
    logic [PROD_W-1:0] div_dividend;
    logic [DV_W-1:0]   div_divisor;
    logic              div_done;
    logic [QW-1:0]     div_quo;
    logic [PROD_W-1:0] div_rem;

    // combinational helpers
    logic [CW-1:0]            in_w, max_w, min_w, rcl_w;
    logic                     srch_ge;
    logic [IDX_W-1:0]         lo_n, hi_n;
    logic [IDX_W:0]           mid_sum;
    logic [RB-1:0]            r_diff;
    logic [IDX_W-1:0]         idx_m1;
    logic [QW-1:0]            frac_w;
    logic signed [TSUM_W-1:0] t_sum;
    logic signed [TSUM_W-1:0] st_ext, t_ext, tmax, t_cl, s_full;
    logic signed [RB:0]       d_diff, d_abs;
    logic [RB-1:0]            d_mag;
    step_t                    rem_lo;
    logic                     idx_clip;
    logic [RB:0]              q_mag;
    logic signed [RB+1:0]     q_pos, q_sgn;
    logic signed [RS_W-1:0]   r_sum;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_comb
    begin
        start_temp_next = start_temp_reg;
        step_next       = step_reg;
        last_next       = last_reg;
        if (cfg_we)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_START: start_temp_next = temperature_t'(pwdata[TEMP_W-1:0]);
                REG_STEP:  step_next       = pwdata[STEP_W-1:0];
                REG_LAST:  last_next       = pwdata[LAST_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_START: prdata = APB_DATA_W'(start_temp_reg);
            REG_STEP:  prdata = APB_DATA_W'(step_reg);
            REG_LAST:  prdata = APB_DATA_W'(last_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_temp_reg <= START_RST;
            step_reg       <= STEP_RST;
            last_reg       <= LAST_RST;
        end
        else
        begin
            start_temp_reg <= start_temp_next;
            step_reg       <= step_next;
            last_reg       <= last_next;
        end
    end

    assign step_eff  = (step_reg == '0) ? STEP_W'(1) : step_reg;
    assign last_wide = LW'(last_reg);

    always_comb
    begin
        if (last_wide > LW'(TABLE_DEPTH - 1))
            last_eff = IDX_W'(TABLE_DEPTH - 1);
        else if (last_wide == '0)
            last_eff = IDX_W'(1);
        else
            last_eff = last_wide[IDX_W-1:0];
    end

    assign last_m1 = last_eff - 1'b1;

    // ---------------- table memory ----------------
    assign accept   = in_item.valid & in_item.ready;
    assign ent_wide = EW'(in_item.entry_index);
    assign mem_we   = accept && (in_item.mode == MODE_LOAD) && (ent_wide < EW'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[ent_wide[IDX_W-1:0]] <= RB'(in_item.resistance);
        end
        rd_data_reg <= table_mem[addr_reg];
    end

    // ---------------- shared units ----------------
    assign r_diff = r_reg - r1_reg;
    assign idx_m1 = idx_reg - 1'b1;
    assign d_diff = $signed({1'b0, rd_data_reg}) - $signed({1'b0, r1_reg});
    assign d_abs  = d_diff[RB] ? -d_diff : d_diff;
    assign d_mag  = d_abs[RB-1:0];

    always_comb
    begin
        mul_a = step_eff;
        mul_b = '0;
        unique case (state_reg)
            M1_R2:                     mul_b = MB'(r_diff);
            M1_DIV, M1_DIVW, M1_FIN:   mul_b = MB'(idx_m1);
            M2_SPAN:                   mul_b = MB'(last_eff);
            M2_R2:
            begin
                mul_a = rem_reg;
                mul_b = MB'(d_mag);
            end
            default: ;
        endcase
    end

    assign mul_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_next;
    end

    // temperature span for mode 2
    assign st_ext = TSUM_W'(start_temp_reg);
    assign t_ext  = TSUM_W'(t_in_reg);
    assign tmax   = st_ext + $signed({2'b00, mul_reg});
    assign t_cl   = (t_ext < st_ext) ? st_ext : ((t_ext > tmax) ? tmax : t_ext);
    assign s_full = t_cl - st_ext;

    always_comb
    begin
        div_start    = 1'b0;
        div_qbits    = CNT_W'(STEP_W);
        div_dividend = mul_reg;
        div_divisor  = DV_W'(step_eff);
        unique case (state_reg)
            M1_DIV:
            begin
                div_start   = 1'b1;
                div_divisor = DV_W'(den_reg);
            end
            M2_CLAMP:
            begin
                div_start    = 1'b1;
                div_qbits    = CNT_W'(IDX_W);
                div_dividend = s_full[PROD_W-1:0];
            end
            M2_DIV:
            begin
                div_start = 1'b1;
                div_qbits = CNT_W'(RB);
            end
            default: ;
        endcase
    end

    rtdi_divider #(
        .DIV_W (PROD_W),
        .DV_W  (DV_W),
        .QW    (QW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .qbits     (div_qbits),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ---------------- datapath helpers ----------------
    assign in_w  = CW'(r_in_reg);
    assign max_w = CW'(rd_data_reg);
    assign min_w = CW'(rmin_reg);
    assign rcl_w = (in_w > max_w) ? max_w : ((in_w < min_w) ? min_w : in_w);

    assign srch_ge = rd_data_reg >= r_reg;
    assign lo_n    = srch_ge ? lo_reg : (addr_reg + 1'b1);
    assign hi_n    = srch_ge ? addr_reg : hi_reg;
    assign mid_sum = (IDX_W+1)'(lo_n) + (IDX_W+1)'(hi_n);

    assign frac_w = frac_en_reg ? div_quo : '0;
    assign t_sum  = st_ext + $signed({2'b00, mul_reg}) + $signed(TSUM_W'(frac_w));

    assign rem_lo   = div_rem[STEP_W-1:0];
    assign idx_clip = div_quo > QW'(last_m1);

    // floor division: a falling segment rounds its magnitude up
    assign q_mag = (RB+1)'(div_quo[RB-1:0]) + (RB+1)'(neg_reg && (div_rem != '0));
    assign q_pos = $signed({1'b0, q_mag});
    assign q_sgn = neg_reg ? -q_pos : q_pos;
    assign r_sum = $signed(RS_W'(r1_reg)) + RS_W'(q_sgn);

    // ---------------- sequencer ----------------
    assign in_item.ready            = (state_reg == ST_IDLE);
    assign out_item.valid           = out_valid_reg;
    assign out_item.temperature_out = t_out_reg;
    assign out_item.resistance_out  = r_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        t_out_next     = t_out_reg;
        r_out_next     = r_out_reg;
        addr_next      = addr_reg;
        r_in_next      = r_in_reg;
        t_in_next      = t_in_reg;
        rmin_next      = rmin_reg;
        r_next         = r_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        r1_next        = r1_reg;
        den_next       = den_reg;
        frac_en_next   = frac_en_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        res_t_next     = res_t_reg;
        res_r_next     = res_r_reg;

        if (out_valid_reg && out_item.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    r_in_next  = in_item.resistance;
                    t_in_next  = in_item.temperature;
                    res_t_next = '0;
                    res_r_next = '0;
                    addr_next  = '0;
                    unique case (in_item.mode)
                        MODE_R2T: state_next = M1_A;
                        MODE_T2R: state_next = M2_SPAN;
                        default:  state_next = ST_EMIT;
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_item.ready)
                begin
                    out_valid_next = 1'b1;
                    t_out_next     = res_t_reg;
                    r_out_next     = res_r_reg;
                    state_next     = ST_IDLE;
                end
            end
            // resistance to temperature
            M1_A:
            begin
                addr_next  = last_eff;
                state_next = M1_B;
            end
            M1_B:
            begin
                rmin_next  = rd_data_reg;
                state_next = M1_C;
            end
            M1_C:
            begin
                r_next     = rcl_w[RB-1:0];
                lo_next    = '0;
                hi_next    = last_eff;
                addr_next  = last_eff >> 1;
                state_next = M1_SW;
            end
            M1_SW:
            begin
                state_next = M1_SC;
            end
            M1_SC:
            begin
                lo_next = lo_n;
                hi_next = hi_n;
                if (lo_n < hi_n)
                begin
                    addr_next  = mid_sum[IDX_W:1];
                    state_next = M1_SW;
                end
                else
                begin
                    state_next = M1_FOUND;
                end
            end
            M1_FOUND:
            begin
                if (lo_reg == '0)
                begin
                    r_next    = rmin_reg;
                    idx_next  = IDX_W'(1);
                    addr_next = '0;
                end
                else
                begin
                    idx_next  = lo_reg;
                    addr_next = lo_reg - 1'b1;
                end
                state_next = M1_R1W;
            end
            M1_R1W:
            begin
                addr_next  = idx_reg;
                state_next = M1_R1;
            end
            M1_R1:
            begin
                r1_next    = rd_data_reg;
                state_next = M1_R2;
            end
            M1_R2:
            begin
                den_next     = rd_data_reg - r1_reg;
                frac_en_next = (rd_data_reg > r1_reg) && (r_reg > r1_reg);
                state_next   = M1_DIV;
            end
            M1_DIV:
            begin
                state_next = M1_DIVW;
            end
            M1_DIVW:
            begin
                if (div_done)
                    state_next = M1_FIN;
            end
            M1_FIN:
            begin
                if (t_sum < TSUM_W'(T_OUT_MIN))
                    res_t_next = TEMP_W'(T_OUT_MIN);
                else if (t_sum > TSUM_W'(T_OUT_MAX))
                    res_t_next = TEMP_W'(T_OUT_MAX);
                else
                    res_t_next = TEMP_W'(t_sum);
                state_next = ST_EMIT;
            end
            // temperature to resistance
            M2_SPAN:
            begin
                state_next = M2_CLAMP;
            end
            M2_CLAMP:
            begin
                state_next = M2_IDXW;
            end
            M2_IDXW:
            begin
                if (div_done)
                    state_next = M2_IDX;
            end
            M2_IDX:
            begin
                // top of the span lands in the last segment at full fraction
                if (idx_clip)
                begin
                    idx_next  = last_m1;
                    rem_next  = rem_lo + step_eff;
                    addr_next = last_m1;
                end
                else
                begin
                    idx_next  = div_quo[IDX_W-1:0];
                    rem_next  = rem_lo;
                    addr_next = div_quo[IDX_W-1:0];
                end
                state_next = M2_R1W;
            end
            M2_R1W:
            begin
                addr_next  = idx_reg + 1'b1;
                state_next = M2_R1;
            end
            M2_R1:
            begin
                r1_next    = rd_data_reg;
                state_next = M2_R2;
            end
            M2_R2:
            begin
                neg_next   = d_diff[RB];
                state_next = M2_DIV;
            end
            M2_DIV:
            begin
                state_next = M2_DIVW;
            end
            M2_DIVW:
            begin
                if (div_done)
                    state_next = M2_FIN;
            end
            M2_FIN:
            begin
                if (r_sum[RS_W-1])
                    res_r_next = '0;
                else if (r_sum > RS_W'(R_OUT_MAX))
                    res_r_next = RES_W'(R_OUT_MAX);
                else
                    res_r_next = r_sum[RES_W-1:0];
                state_next = ST_EMIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            t_out_reg     <= '0;
            r_out_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            t_out_reg     <= t_out_next;
            r_out_reg     <= r_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        r_in_reg    <= r_in_next;
        t_in_reg    <= t_in_next;
        rmin_reg    <= rmin_next;
        r_reg       <= r_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        idx_reg     <= idx_next;
        r1_reg      <= r1_next;
        den_reg     <= den_next;
        frac_en_reg <= frac_en_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        res_t_reg   <= res_t_next;
        res_r_reg   <= res_r_next;
    end

endmodule
